### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KTSP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KTSP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ktsp_pkg.sv
// Shared constants, types and the saturation helper of the k-transaction profit core.
// No dependencies.
package ktsp_pkg;

	localparam int DEPTH       = 128;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int PRICE_W     = 16;
	localparam int PROFIT_W    = 32;
	localparam int BEST_W      = 31;
	localparam int TRADES_W    = 8;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;

	typedef logic signed [PROFIT_W-1:0] profit_t;

	typedef struct packed {
		logic              start;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              finish;
	} ktsp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} ktsp_status_t;

	// clamp a sum one bit wider than a profit to the signed profit range
	function automatic profit_t sat_profit(input logic signed [PROFIT_W:0] s);
		profit_t r;
		if (s[PROFIT_W] != s[PROFIT_W-1]) begin
			r = s[PROFIT_W] ? {1'b1, {(PROFIT_W-1){1'b0}}} : {1'b0, {(PROFIT_W-1){1'b1}}};
		end else begin
			r = s[PROFIT_W-1:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/ktsp_ctrl.sv
// Controller of the k-transaction profit core: input handshake, entry sweep, drain.
// Depends on ktsp_pkg.
module ktsp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_free,
	input  ktsp_pkg::ktsp_status_t status,
	output ktsp_pkg::ktsp_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                   state_q;
	logic [ktsp_pkg::ADDR_W-1:0]  addr_q;
	logic                         accept;
	logic                         finish;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign finish   = (state_q == ST_DRAIN) && !status.pipe_busy && out_free;

	always_comb begin
		cmd.start   = accept;
		cmd.rd_en   = (state_q == ST_RUN);
		cmd.rd_addr = addr_q;
		cmd.finish  = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						addr_q  <= '0;
					end
				end
				ST_RUN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ktsp_pkg::ADDR_W'(ktsp_pkg::DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/ktsp_datapath.sv
// Datapath of the k-transaction profit core: profit tables, valid bits, update and best search.
// Depends on ktsp_pkg.
module ktsp_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ktsp_pkg::ktsp_cmd_t                cmd,
	output ktsp_pkg::ktsp_status_t             status,
	input  logic [ktsp_pkg::PRICE_W-1:0]       in_price,
	input  logic                               in_last,
	input  logic [ktsp_pkg::TRADES_W-1:0]      max_trades,
	output logic [ktsp_pkg::BEST_W-1:0]        best,
	output logic                               last
);

	ktsp_pkg::profit_t nh_mem [ktsp_pkg::DEPTH];
	ktsp_pkg::profit_t h_mem  [ktsp_pkg::DEPTH];

	logic [ktsp_pkg::PRICE_W-1:0]  price_q;
	logic                          last_q;
	logic                          valid_s1;
	logic [ktsp_pkg::ADDR_W-1:0]   addr_s1;
	ktsp_pkg::profit_t             nh_rd_s1;
	ktsp_pkg::profit_t             h_rd_s1;
	logic [ktsp_pkg::DEPTH-1:0]    nhv_q;
	logic [ktsp_pkg::DEPTH-1:0]    hv_q;
	ktsp_pkg::profit_t             prev_nh_q;
	logic                          prev_nhv_q;
	logic                          valid_s2;
	ktsp_pkg::profit_t             nh_s2;
	logic                          nhv_s2;
	logic                          lim_s2;
	logic [ktsp_pkg::BEST_W-1:0]   best_q;

	logic                          nhv_old;
	logic                          hv_old;
	ktsp_pkg::profit_t             cand_nh;
	ktsp_pkg::profit_t             cand_h;
	ktsp_pkg::profit_t             nh_new;
	ktsp_pkg::profit_t             h_new;
	logic                          nhv_new;
	logic                          hv_new;
	logic                          take_nh;
	logic                          take_h;
	logic                          in_lim;

	always_comb begin
		nhv_old = nhv_q[addr_s1];
		hv_old  = hv_q[addr_s1];
		cand_nh = ktsp_pkg::sat_profit({h_rd_s1[ktsp_pkg::PROFIT_W-1], h_rd_s1}
			+ (ktsp_pkg::PROFIT_W+1)'(price_q));
		cand_h  = ktsp_pkg::sat_profit({prev_nh_q[ktsp_pkg::PROFIT_W-1], prev_nh_q}
			- (ktsp_pkg::PROFIT_W+1)'(price_q));
		take_nh = hv_old && (!nhv_old || (cand_nh > nh_rd_s1));
		take_h  = prev_nhv_q && (!hv_old || (cand_h > h_rd_s1));
		nh_new  = take_nh ? cand_nh : nh_rd_s1;
		h_new   = take_h ? cand_h : h_rd_s1;
		nhv_new = nhv_old || hv_old;
		hv_new  = hv_old || prev_nhv_q;
		in_lim  = ktsp_pkg::TRADES_W'(addr_s1) < max_trades;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			nh_rd_s1 <= nh_mem[cmd.rd_addr];
			h_rd_s1  <= h_mem[cmd.rd_addr];
			addr_s1  <= cmd.rd_addr;
		end
		if (valid_s1) begin
			nh_mem[addr_s1] <= nh_new;
			h_mem[addr_s1]  <= h_new;
			nh_s2           <= nh_new;
			nhv_s2          <= nhv_new;
			lim_s2          <= in_lim;
		end
		if (cmd.start) begin
			price_q <= in_price;
			last_q  <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			nhv_q      <= '0;
			hv_q       <= '0;
			prev_nh_q  <= '0;
			prev_nhv_q <= 1'b1;
			best_q     <= '0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			if (cmd.finish && last_q) begin
				nhv_q <= '0;
				hv_q  <= '0;
			end else if (valid_s1) begin
				nhv_q[addr_s1] <= nhv_new;
				hv_q[addr_s1]  <= hv_new;
			end
			if (cmd.start) begin
				prev_nh_q  <= '0;
				prev_nhv_q <= 1'b1;
			end else if (valid_s1) begin
				prev_nh_q  <= nh_rd_s1;
				prev_nhv_q <= nhv_old;
			end
			if (cmd.start) begin
				best_q <= '0;
			end else if (valid_s2 && nhv_s2 && lim_s2 && !nh_s2[ktsp_pkg::PROFIT_W-1]
				&& (nh_s2[ktsp_pkg::BEST_W-1:0] > best_q)) begin
				best_q <= nh_s2[ktsp_pkg::BEST_W-1:0];
			end
		end
	end

	assign status.pipe_busy = valid_s1 || valid_s2;
	assign best             = best_q;
	assign last             = last_q;

endmodule

### hw/rtl/k_transaction_stock_profit_dp_core.sv
// Top level of the k-transaction stock profit core: ports, config register, result register.
// Depends on ktsp_pkg, ktsp_ctrl, ktsp_datapath and assert_macros.svh.
//
//  channel   direction  signals                      content
//  s_        in         tvalid tready tdata tlast    price, last day flag
//  m_        out        tvalid tready tdata tlast    best profit, end of sequence
//  cfg_      in         valid ready data             max_trades
//
// Each item sweeps all 128 table entries, one per cycle through one read and one write
// port, then drains until the pipeline is empty and the result register is free.
// One item is in work at a time; the next is taken while a result waits in the output register.
// Reset clears all valid bits at once, so every entry reads as minus infinity.
// A stalled output holds the finished item in the datapath until the result register frees.
`include "assert_macros.svh"

module k_transaction_stock_profit_dp_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ktsp_pkg::IN_TDATA_W-1:0]      s_tdata,   // [15:0] price
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ktsp_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [30:0] best_profit, [31] zero
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ktsp_pkg::TRADES_W-1:0]        cfg_data
);

	ktsp_pkg::ktsp_cmd_t               cmd;
	ktsp_pkg::ktsp_status_t            status;
	logic [ktsp_pkg::TRADES_W-1:0]     max_trades_q;
	logic                              out_valid_q;
	logic [ktsp_pkg::BEST_W-1:0]       best_profit_q;
	logic                              seq_end_q;
	logic                              out_free;
	logic [ktsp_pkg::BEST_W-1:0]       dp_best;
	logic                              dp_last;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	ktsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd)
	);

	ktsp_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_price   (s_tdata[ktsp_pkg::PRICE_W-1:0]),
		.in_last    (s_tlast),
		.max_trades (max_trades_q),
		.best       (dp_best),
		.last       (dp_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_trades_q <= ktsp_pkg::TRADES_W'(1);
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_trades_q <= cfg_data;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			best_profit_q <= dp_best;
			seq_end_q     <= dp_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(ktsp_pkg::OUT_TDATA_W - ktsp_pkg::BEST_W){1'b0}}, best_profit_q};
	assign m_tlast  = seq_end_q;

	`KTSP_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready held after accept")
	`KTSP_ASSERT_IMP(a_sweep_not_idle, cmd.rd_en, !s_tready, "entry sweep while idle")
	`KTSP_ASSERT_IMP(a_finish_drained, cmd.finish, !status.pipe_busy, "result taken before drain")
	`KTSP_ASSERT_NXT(a_finish_shows, cmd.finish, m_tvalid, "finished item not presented")

endmodule

### sim/tb.sv
// Self-checking bench for the k-transaction stock profit core: streams daily prices under
// several max_trades settings and checks every result, best profit and end flag, against its own tables.
// Depends on ktsp_pkg and k_transaction_stock_profit_dp_core.
module tb;
	import ktsp_pkg::*;

	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int STALL_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 300;
	localparam longint PROFIT_MAX  = 64'sd2147483647;
	localparam longint PROFIT_MIN  = -64'sd2147483648;

	typedef enum int {SHAPE_UNIFORM, SHAPE_SWING, SHAPE_DRIFT, SHAPE_STEPS} price_shape_t;
	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               last_day;
	} day_t;

	typedef struct packed {
		logic [BEST_W-1:0] best;
		logic              seq_end;
	} profit_res_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] price
	logic                   s_tlast   = 1'b0;
	logic                   m_tready  = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [TRADES_W-1:0]    cfg_data  = '0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_TDATA_W-1:0] m_tdata;          // [30:0] best_profit, [31] zero
	logic                   m_tlast;
	logic                   cfg_ready;

	day_t        day_q[$];
	profit_res_t profit_exp_q[$];

	logic [TRADES_W-1:0] trades_limit = 1;
	profit_t cash_val[0:DEPTH];
	bit      cash_ok[0:DEPTH];
	profit_t stock_val[1:DEPTH];
	bit      stock_ok[1:DEPTH];

	int       errs         = 0;
	int       idle_cycles  = 0;
	int       burst_left   = 0;
	int       gap_left     = 0;
	int       hold_left    = 0;
	int       results_seen = 0;
	int       rx_tick      = 0;
	bit       held_once    = 1'b0;
	rx_mode_t rx_mode      = RX_ALWAYS;

	k_transaction_stock_profit_dp_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic profit_t clamp_profit(longint v);
		if (v > PROFIT_MAX)
			return profit_t'(PROFIT_MAX);
		if (v < PROFIT_MIN)
			return profit_t'(PROFIT_MIN);
		return profit_t'(v);
	endfunction

	function automatic void clear_tables();
		for (int j = 0; j <= DEPTH; j++) begin
			cash_val[j] = '0;
			cash_ok[j]  = 1'b0;
		end
		for (int j = 1; j <= DEPTH; j++) begin
			stock_val[j] = '0;
			stock_ok[j]  = 1'b0;
		end
		cash_ok[0] = 1'b1;
	endfunction

	// walk every transaction count from the top so that entry j-1 still holds yesterday
	function automatic void advance_day(logic [PRICE_W-1:0] price, logic last_day);
		longint      p;
		longint      best;
		int          cap;
		profit_t     cand;
		profit_res_t res;
		p    = longint'(price);
		best = 0;
		cap  = (trades_limit > DEPTH) ? DEPTH : int'(trades_limit);
		for (int j = DEPTH; j >= 1; j--) begin
			if (stock_ok[j]) begin
				cand = clamp_profit(longint'(stock_val[j]) + p);
				if (!cash_ok[j] || cand > cash_val[j]) begin
					cash_val[j] = cand;
					cash_ok[j]  = 1'b1;
				end
			end
			if (cash_ok[j-1]) begin
				cand = clamp_profit(longint'(cash_val[j-1]) - p);
				if (!stock_ok[j] || cand > stock_val[j]) begin
					stock_val[j] = cand;
					stock_ok[j]  = 1'b1;
				end
			end
		end
		for (int j = 1; j <= cap; j++) begin
			if (cash_ok[j] && longint'(cash_val[j]) > best)
				best = longint'(cash_val[j]);
		end
		res.best    = best[BEST_W-1:0];
		res.seq_end = last_day;
		profit_exp_q.push_back(res);
		if (last_day)
			clear_tables();
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		errs++;
	endtask

	// price driver: bursts of items with random gaps
	always @(posedge clk) begin : price_drv
		day_t day;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				advance_day(s_tdata[PRICE_W-1:0], s_tlast);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (day_q.size() != 0) begin
					day = day_q.pop_front();
					s_tdata  <= day.price;
					s_tlast  <= day.last_day;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk) begin : profit_mon
		profit_res_t want;
		if (arst_n) begin
			rx_tick++;
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (profit_exp_q.size() == 0) begin
					report_mismatch("unexpected result", longint'(m_tdata[BEST_W-1:0]), -1);
				end else begin
					want = profit_exp_q.pop_front();
					if (m_tdata[BEST_W-1:0] !== want.best)
						report_mismatch("best_profit", longint'(m_tdata[BEST_W-1:0]),
							longint'(want.best));
					if (m_tlast !== want.seq_end)
						report_mismatch("sequence_end", longint'(m_tlast), longint'(want.seq_end));
					if (m_tdata[OUT_TDATA_W-1:BEST_W] !== '0)
						report_mismatch("tdata pad", longint'(m_tdata[OUT_TDATA_W-1:BEST_W]), 0);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held_once && results_seen == 300) begin
				held_once = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_RANDOM:  m_tready <= ($urandom_range(0, 1) == 1);
					RX_PATTERN: m_tready <= (rx_tick % 5 != 0) && (rx_tick[5:4] != 2'b11);
					default:    m_tready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("tb failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_day(int price, bit last_day);
		day_t day;
		day.price    = price[PRICE_W-1:0];
		day.last_day = last_day;
		day_q.push_back(day);
	endtask

	task automatic push_sequence(int len, bit close);
		price_shape_t shape;
		int           level;
		shape = price_shape_t'($urandom_range(0, 3));
		level = $urandom_range(0, 65535);
		for (int i = 0; i < len; i++) begin
			case (shape)
				SHAPE_SWING: level = (i % 2) ? $urandom_range(65000, 65535) : $urandom_range(0, 500);
				SHAPE_DRIFT: begin
					level += int'($urandom_range(0, 200)) - 100;
					if (level < 0)
						level = 0;
					if (level > 65535)
						level = 65535;
				end
				SHAPE_STEPS: level = $urandom_range(0, 15) * 4369;
				default:     level = $urandom_range(0, 65535);
			endcase
			push_day(level, close && (i == len - 1));
		end
	endtask

	task automatic wait_drained();
		while (day_q.size() != 0 || s_tvalid || profit_exp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_trades(logic [TRADES_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		trades_limit = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [TRADES_W-1:0] trades, int days, rx_mode_t mode, bit close);
		int len;
		write_trades(trades);
		rx_mode = mode;
		while (days > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
			if (len > days)
				len = days;
			days -= len;
			push_sequence(len, close || days > 0);
		end
	endtask

	initial begin
		clear_tables();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// one trade from reset
		push_day(100, 0); push_day(50, 0); push_day(200, 1);
		push_day(65535, 1);
		push_day(0, 0); push_day(65535, 1);
		push_day(65535, 0); push_day(0, 1);
		push_day(5, 0); push_day(3, 0); push_day(9, 0); push_day(1, 0); push_day(7, 1);

		write_trades(2);
		push_day(5, 0); push_day(3, 0); push_day(9, 0); push_day(1, 0); push_day(7, 1);

		write_trades(0);
		push_day(1, 0); push_day(9, 1);

		// above the table depth
		write_trades(255);
		push_day(3, 0); push_day(1, 0); push_day(4, 0); push_day(1, 0); push_day(5, 0);
		push_day(9, 1);

		run_phase(1, 170, RX_ALWAYS, 1);
		run_phase(128, 170, RX_RANDOM, 0);
		run_phase(3, 170, RX_PATTERN, 1);
		run_phase(129, 170, RX_RANDOM, 1);
		run_phase(0, 120, RX_PATTERN, 1);
		run_phase(255, 170, RX_ALWAYS, 1);
		run_phase(TRADES_W'($urandom_range(1, 8)), 170, RX_RANDOM, 1);
		run_phase(TRADES_W'($urandom_range(0, 255)), 170, RX_PATTERN, 1);
		run_phase(128, 170, RX_RANDOM, 1);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errs == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ktsp_pkg.sv
hw/rtl/ktsp_ctrl.sv
hw/rtl/ktsp_datapath.sv
hw/rtl/k_transaction_stock_profit_dp_core.sv
sim/tb.sv
